/* rtl/imufps_pkg.sv */
// ----------------------------------------------------------------------------
// imufps_pkg
// Shared types, constants and the axis scaling function of the inertial
// sensor frame parser and scaler.
// ----------------------------------------------------------------------------
package imufps_pkg;

  // fraction bits of the scaled outputs, 8 to 16
  localparam int FRAC_BITS = 16;

  localparam logic [7:0] HDR_BYTE   = 8'h55;
  localparam logic [7:0] TYPE_ACC   = 8'h51;
  localparam logic [7:0] TYPE_RATE  = 8'h52;
  localparam logic [7:0] TYPE_ANGLE = 8'h53;

  // byte count of the last byte of a frame (frame is 11 bytes)
  localparam logic [3:0] LAST_IDX = 4'd10;

  localparam int RAW_W    = 16;
  localparam int SCALED_W = 28;
  localparam int PROD_W   = 24;
  localparam int EXT_W    = 40;

  // k * 2^FRAC_BITS / 2^15 = mult * 2^shift
  // 16 = 1 * 2^4, 2000 = 125 * 2^4, 180 = 45 * 2^2
  localparam logic signed [7:0] MULT_ACC   = 8'sd1;
  localparam logic signed [7:0] MULT_RATE  = 8'sd125;
  localparam logic signed [7:0] MULT_ANGLE = 8'sd45;
  localparam int SH_ACC   = FRAC_BITS + 4 - 15;
  localparam int SH_RATE  = FRAC_BITS + 4 - 15;
  localparam int SH_ANGLE = FRAC_BITS + 2 - 15;

  typedef enum logic [1:0] {
    KIND_ACC   = 2'd0,
    KIND_RATE  = 2'd1,
    KIND_ANGLE = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e                   kind;
    logic signed [RAW_W-1:0] raw_x;
    logic signed [RAW_W-1:0] raw_y;
    logic signed [RAW_W-1:0] raw_z;
  } frame_t;

  // floor(raw * mult * 2^shift), shift may be negative
  function automatic logic signed [SCALED_W-1:0] shift_prod(
    input logic signed [PROD_W-1:0] prod,
    input int                       sh
  );
    logic signed [EXT_W-1:0] ext;
    logic signed [EXT_W-1:0] res;
    ext = EXT_W'(prod);
    if (sh >= 0) begin
      res = ext <<< sh;
    end else begin
      res = ext >>> (-sh);
    end
    return res[SCALED_W-1:0];
  endfunction

  function automatic logic signed [SCALED_W-1:0] scale_axis(
    input logic signed [RAW_W-1:0] raw,
    input kind_e                   kind
  );
    logic signed [PROD_W-1:0]   prod;
    logic signed [SCALED_W-1:0] res;
    prod = '0;
    res  = '0;
    unique case (kind)
      KIND_ACC: begin
        prod = PROD_W'(raw) * PROD_W'(MULT_ACC);
        res  = shift_prod(prod, SH_ACC);
      end
      KIND_RATE: begin
        prod = PROD_W'(raw) * PROD_W'(MULT_RATE);
        res  = shift_prod(prod, SH_RATE);
      end
      KIND_ANGLE: begin
        prod = PROD_W'(raw) * PROD_W'(MULT_ANGLE);
        res  = shift_prod(prod, SH_ANGLE);
      end
      default: begin
        res = '0;
      end
    endcase
    return res;
  endfunction

endpackage

/* rtl/imu_frame_parser_scaler.sv */
// ----------------------------------------------------------------------------
// imu_frame_parser_scaler
// Inertial sensor serial frame parser with fixed-point axis scaling.
// ----------------------------------------------------------------------------
// Takes one received byte per cycle. Bytes are dropped until the header 0x55,
// then an 11-byte frame is collected; frames of type 0x51 (acceleration),
// 0x52 (angular rate) and 0x53 (angle) give one result item carrying the
// three raw little-endian axis words and their values in g, deg/s or deg with
// FRAC_BITS fraction bits. Other types, temperature and checksum are ignored.
// A result reaches the master side through the queue and the output register
// after the frame's last byte is taken. The parser feeds the scaler through a
// two-entry queue; s_axis_tready drops only while that queue is full, which
// needs the output to stall for more than a full frame. Each scaled axis costs
// one constant multiply and a fixed shift just before the output register.
// ----------------------------------------------------------------------------
module imu_frame_parser_scaler import imufps_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,  // rx_byte
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // raw_x, raw_y, raw_z, scaled_x, scaled_y, scaled_z, zero pad
  output logic [135:0] m_axis_tdata,
  output logic [1:0]   m_axis_tuser   // kind
);

  logic   push, push_ready;
  frame_t push_frame;
  logic   pop_valid, pop_ready;
  frame_t pop_frame;
  kind_e  kind;
  logic signed [RAW_W-1:0]    raw_x, raw_y, raw_z;
  logic signed [SCALED_W-1:0] scaled_x, scaled_y, scaled_z;

  imufps_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_valid_i (s_axis_tvalid),
    .byte_ready_o (s_axis_tready),
    .byte_i       (s_axis_tdata),
    .push_o       (push),
    .push_ready_i (push_ready),
    .frame_o      (push_frame)
  );

  imufps_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_ready_o (push_ready),
    .push_data_i  (push_frame),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_frame)
  );

  imufps_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (pop_valid),
    .in_ready_o  (pop_ready),
    .in_data_i   (pop_frame),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .kind_o      (kind),
    .raw_x_o     (raw_x),
    .raw_y_o     (raw_y),
    .raw_z_o     (raw_z),
    .scaled_x_o  (scaled_x),
    .scaled_y_o  (scaled_y),
    .scaled_z_o  (scaled_z)
  );

  assign m_axis_tuser = kind;
  assign m_axis_tdata = {4'b0000, scaled_z, scaled_y, scaled_x, raw_z, raw_y, raw_x};

endmodule

/* rtl/imufps_front.sv */
// ----------------------------------------------------------------------------
// imufps_front
// Header hunt, byte counting and frame collection; pushes one frame record
// per complete frame of a known type.
// ----------------------------------------------------------------------------
module imufps_front import imufps_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       byte_valid_i,
  output logic       byte_ready_o,
  input  logic [7:0] byte_i,
  output logic       push_o,
  input  logic       push_ready_i,
  output frame_t     frame_o
);

  logic [3:0] count_q, count_d;
  logic [7:0] type_q, type_d;
  logic [7:0] payload_q [6];
  logic [3:0] n;
  logic       accept;
  logic       type_ok;
  kind_e      kind;

  assign byte_ready_o = push_ready_i;
  assign accept       = byte_valid_i && push_ready_i;
  assign n            = (count_q > LAST_IDX) ? 4'd0 : count_q;

  always_comb begin
    type_ok = 1'b1;
    kind    = KIND_ACC;
    unique case (type_q)
      TYPE_ACC:   kind = KIND_ACC;
      TYPE_RATE:  kind = KIND_RATE;
      TYPE_ANGLE: kind = KIND_ANGLE;
      default:    type_ok = 1'b0;
    endcase
  end

  always_comb begin
    count_d = count_q;
    type_d  = type_q;
    if (accept) begin
      if (n == 4'd0) begin
        count_d = (byte_i == HDR_BYTE) ? 4'd1 : 4'd0;
      end else if (n == LAST_IDX) begin
        count_d = 4'd0;
      end else begin
        count_d = n + 4'd1;
      end
      if (n == 4'd1) begin
        type_d = byte_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      type_q  <= '0;
    end else begin
      count_q <= count_d;
      type_q  <= type_d;
    end
  end

  // payload bytes 2..7 of the frame
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 6; i++) begin
      if (accept && (n == 4'(i + 2))) begin
        payload_q[i] <= byte_i;
      end
    end
  end

  assign push_o        = accept && (n == LAST_IDX) && type_ok;
  assign frame_o.kind  = kind;
  assign frame_o.raw_x = {payload_q[1], payload_q[0]};
  assign frame_o.raw_y = {payload_q[3], payload_q[2]};
  assign frame_o.raw_z = {payload_q[5], payload_q[4]};

endmodule

/* rtl/imufps_fifo.sv */
// ----------------------------------------------------------------------------
// imufps_fifo
// Two-entry queue of frame records between the parser and the scaler.
// ----------------------------------------------------------------------------
module imufps_fifo import imufps_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  output logic   push_ready_o,
  input  frame_t push_data_i,
  output logic   pop_valid_o,
  input  logic   pop_ready_i,
  output frame_t pop_data_o
);

  frame_t     mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] fill_q, fill_d;
  logic       do_push, do_pop;

  assign push_ready_o = (fill_q != 2'd2);
  assign pop_valid_o  = (fill_q != 2'd0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign do_push      = push_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  always_comb begin
    fill_d = fill_q;
    if (do_push && !do_pop) begin
      fill_d = fill_q + 2'd1;
    end else if (do_pop && !do_push) begin
      fill_d = fill_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= '0;
    end else begin
      fill_q <= fill_d;
      if (do_push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

/* rtl/imufps_back.sv */
// ----------------------------------------------------------------------------
// imufps_back
// Scales the three axes of a frame record by constant multiply and shift and
// holds the result in the output register.
// ----------------------------------------------------------------------------
module imufps_back import imufps_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  frame_t                     in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output kind_e                      kind_o,
  output logic signed [RAW_W-1:0]    raw_x_o,
  output logic signed [RAW_W-1:0]    raw_y_o,
  output logic signed [RAW_W-1:0]    raw_z_o,
  output logic signed [SCALED_W-1:0] scaled_x_o,
  output logic signed [SCALED_W-1:0] scaled_y_o,
  output logic signed [SCALED_W-1:0] scaled_z_o
);

  logic                       valid_q;
  logic                       load;
  frame_t                     frame_q;
  logic signed [SCALED_W-1:0] sx_q, sy_q, sz_q;

  assign in_ready_o = !valid_q || out_ready_i;
  assign load       = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      frame_q <= in_data_i;
      sx_q    <= scale_axis(in_data_i.raw_x, in_data_i.kind);
      sy_q    <= scale_axis(in_data_i.raw_y, in_data_i.kind);
      sz_q    <= scale_axis(in_data_i.raw_z, in_data_i.kind);
    end
  end

  assign out_valid_o = valid_q;
  assign kind_o      = frame_q.kind;
  assign raw_x_o     = frame_q.raw_x;
  assign raw_y_o     = frame_q.raw_y;
  assign raw_z_o     = frame_q.raw_z;
  assign scaled_x_o  = sx_q;
  assign scaled_y_o  = sy_q;
  assign scaled_z_o  = sz_q;

endmodule

/* rtl/imufps_checker.sv */
// ----------------------------------------------------------------------------
// imufps_checker
// Port-level checks of the frame parser and scaler, bound to the top level.
// ----------------------------------------------------------------------------
module imufps_checker import imufps_pkg::*; (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [135:0] m_axis_tdata,
  input logic [1:0]   m_axis_tuser
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result item dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result item changed while stalled");

  a_kind_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser == KIND_ACC) || (m_axis_tuser == KIND_RATE) ||
                      (m_axis_tuser == KIND_ANGLE))
    else $error("kind outside the three frame types");

  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[135:132] == 4'b0000))
    else $error("tdata padding not zero");

  // an empty output only fills with a frame whose last byte was taken and
  // then passed through the queue and the output register
  a_fill_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
    else $error("result item without a recent frame");

endmodule

bind imu_frame_parser_scaler imufps_checker u_imufps_checker (.*);

/* tb/sv/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the inertial sensor frame parser and scaler.
// ----------------------------------------------------------------------------
// A queue of received bytes feeds the slave side. It starts with a few noise
// bytes and two hand-built frames, then mostly well-formed frames with random
// axis words, plus noise, cut-short frames and frames of unknown type. Every
// accepted byte steps a local frame parser that queues the expected result.
// Each result taken on the master side is checked field by field against
// that queue. Sender gaps and receiver stalls change over four phases.
// ----------------------------------------------------------------------------
module tb;
  import imufps_pkg::*;

  localparam int HALF_PERIOD  = 6;
  localparam int RESET_CYCLES = 5;
  localparam int TARGET_BYTES = 1700;
  localparam int WATCHDOG_MAX = 4000;
  localparam int TAIL_CYCLES  = 10;
  localparam int MAX_PRINTED  = 40;

  localparam logic [3:0] FRAME_LEN  = 4'd11;
  localparam int         GAIN_ACC   = 16;
  localparam int         GAIN_RATE  = 2000;
  localparam int         GAIN_ANGLE = 180;

  // idle phases
  localparam logic [1:0] PH_NONE   = 2'd0;
  localparam logic [1:0] PH_SENDER = 2'd1;
  localparam logic [1:0] PH_RECV   = 2'd2;
  localparam logic [1:0] PH_BOTH   = 2'd3;

  typedef struct packed {
    kind_e                   kind;
    logic [RAW_W-1:0]        raw_x;
    logic [RAW_W-1:0]        raw_y;
    logic [RAW_W-1:0]        raw_z;
    logic [SCALED_W-1:0]     scaled_x;
    logic [SCALED_W-1:0]     scaled_y;
    logic [SCALED_W-1:0]     scaled_z;
  } imu_sample_t;

  logic         clk_i         = 1'b0;
  logic         rst_ni        = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [7:0]   s_axis_tdata  = 8'h00;  // rx_byte
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  // raw_x, raw_y, raw_z, scaled_x, scaled_y, scaled_z, zero pad
  logic [135:0] m_axis_tdata;
  logic [1:0]   m_axis_tuser;           // kind

  logic [7:0]   rx_bytes[$];
  imu_sample_t  expected_samples[$];
  int           stim_total    = 0;
  int           bytes_sent    = 0;
  int           mismatches    = 0;
  int           idle_cycles   = 0;
  logic [1:0]   phase         = PH_NONE;

  // local copy of the parser state
  logic [3:0]   frame_cnt     = 4'd0;
  logic [7:0]   frame_type    = 8'h00;
  logic [7:0]   payload[6];

  imu_frame_parser_scaler dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #(HALF_PERIOD) clk_i = ~clk_i;

  // floor(raw * gain * 2^FRAC_BITS / 32768), wrapped to the output width
  function automatic logic [SCALED_W-1:0] scaled_axis(input logic [RAW_W-1:0] raw,
                                                      input int gain);
    longint prod;
    longint quot;
    prod = longint'($signed(raw)) * longint'(gain);
    prod = prod * (longint'(1) << FRAC_BITS);
    quot = prod >>> 15;
    return quot[SCALED_W-1:0];
  endfunction

  task automatic parse_rx_byte(input logic [7:0] rx);
    logic [3:0]  cnt;
    imu_sample_t sample;
    int          gain;
    cnt = (frame_cnt >= FRAME_LEN) ? 4'd0 : frame_cnt;
    gain = 0;
    if (cnt == 4'd0) begin
      frame_cnt = (rx == HDR_BYTE) ? 4'd1 : 4'd0;
    end else begin
      if (cnt == 4'd1) begin
        frame_type = rx;
      end else if (cnt <= 4'd7) begin
        payload[cnt - 4'd2] = rx;
      end
      if (cnt + 4'd1 < FRAME_LEN) begin
        frame_cnt = cnt + 4'd1;
      end else begin
        frame_cnt = 4'd0;
        sample = '0;
        case (frame_type)
          TYPE_ACC: begin
            sample.kind = KIND_ACC;
            gain = GAIN_ACC;
          end
          TYPE_RATE: begin
            sample.kind = KIND_RATE;
            gain = GAIN_RATE;
          end
          TYPE_ANGLE: begin
            sample.kind = KIND_ANGLE;
            gain = GAIN_ANGLE;
          end
          default: gain = 0;
        endcase
        if (gain != 0) begin
          sample.raw_x    = {payload[1], payload[0]};
          sample.raw_y    = {payload[3], payload[2]};
          sample.raw_z    = {payload[5], payload[4]};
          sample.scaled_x = scaled_axis(sample.raw_x, gain);
          sample.scaled_y = scaled_axis(sample.raw_y, gain);
          sample.scaled_z = scaled_axis(sample.raw_z, gain);
          expected_samples.push_back(sample);
        end
      end
    end
  endtask

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MAX_PRINTED) begin
      $display("%0t ns: mismatch: %s", $time, msg);
    end
  endtask

  task automatic check_field(input string name, input logic [SCALED_W-1:0] got,
                             input logic [SCALED_W-1:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %h expected %h", name, got, want));
    end
  endtask

  task automatic check_sample();
    imu_sample_t want;
    if (expected_samples.size() == 0) begin
      report_mismatch($sformatf("result with none pending, tuser %0d tdata %h",
                                m_axis_tuser, m_axis_tdata));
    end else begin
      want = expected_samples.pop_front();
      check_field("kind",     SCALED_W'(m_axis_tuser),        SCALED_W'(want.kind));
      check_field("raw_x",    SCALED_W'(m_axis_tdata[15:0]),  SCALED_W'(want.raw_x));
      check_field("raw_y",    SCALED_W'(m_axis_tdata[31:16]), SCALED_W'(want.raw_y));
      check_field("raw_z",    SCALED_W'(m_axis_tdata[47:32]), SCALED_W'(want.raw_z));
      check_field("scaled_x", m_axis_tdata[75:48],            want.scaled_x);
      check_field("scaled_y", m_axis_tdata[103:76],           want.scaled_y);
      check_field("scaled_z", m_axis_tdata[131:104],          want.scaled_z);
      check_field("pad",      SCALED_W'(m_axis_tdata[135:132]), '0);
    end
  endtask

  // axis words lean toward the extremes now and then
  function automatic logic [15:0] pick_axis();
    case ($urandom_range(0, 11))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'hFFFF;
      3:       return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic push_frame(input logic [7:0] ftype, input logic [15:0] ax,
                            input logic [15:0] ay, input logic [15:0] az);
    rx_bytes.push_back(HDR_BYTE);
    rx_bytes.push_back(ftype);
    rx_bytes.push_back(ax[7:0]);
    rx_bytes.push_back(ax[15:8]);
    rx_bytes.push_back(ay[7:0]);
    rx_bytes.push_back(ay[15:8]);
    rx_bytes.push_back(az[7:0]);
    rx_bytes.push_back(az[15:8]);
    // temperature and checksum
    repeat (3) rx_bytes.push_back(8'($urandom));
  endtask

  task automatic build_stimulus();
    logic [7:0] ftype;
    int         pick;
    // hunting over noise, then a rate frame and an angle frame with header bytes inside them
    rx_bytes.push_back(8'h00);
    rx_bytes.push_back(8'hFF);
    rx_bytes.push_back(8'hAA);
    rx_bytes = {rx_bytes, 8'h55, 8'h52, 8'h00, 8'h80, 8'hFF, 8'h7F, 8'hFF, 8'hFF,
                8'h55, 8'h55, 8'h00};
    rx_bytes = {rx_bytes, 8'h55, 8'h53, 8'h55, 8'h55, 8'h00, 8'h80, 8'h01, 8'h00,
                8'h12, 8'h34, 8'h56};
    while (rx_bytes.size() < TARGET_BYTES) begin
      pick = $urandom_range(0, 19);
      if (pick < 2) begin
        repeat ($urandom_range(1, 4)) rx_bytes.push_back(8'($urandom));
      end else if (pick < 4) begin
        // cut-short frame, the next frame gets swallowed into it
        rx_bytes.push_back(HDR_BYTE);
        repeat ($urandom_range(1, 9)) rx_bytes.push_back(8'($urandom));
      end else if (pick < 6) begin
        ftype = 8'($urandom);
        if (ftype == TYPE_ACC || ftype == TYPE_RATE || ftype == TYPE_ANGLE) begin
          ftype = HDR_BYTE;
        end
        push_frame(ftype, pick_axis(), pick_axis(), pick_axis());
      end else begin
        case ($urandom_range(0, 2))
          0:       ftype = TYPE_ACC;
          1:       ftype = TYPE_RATE;
          default: ftype = TYPE_ANGLE;
        endcase
        push_frame(ftype, pick_axis(), pick_axis(), pick_axis());
      end
    end
    stim_total = rx_bytes.size();
  endtask

  // sender
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= 8'h00;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        parse_rx_byte(s_axis_tdata);
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (rx_bytes.size() != 0 &&
            $urandom_range(0, 99) >= ((phase == PH_SENDER) ? 51 :
                                      (phase == PH_BOTH) ? 26 : 0)) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= rx_bytes.pop_front();
          bytes_sent++;
          phase <= 2'((bytes_sent * 4) / (stim_total + 1));
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        check_sample();
      end
      m_axis_tready <= $urandom_range(0, 99) >= ((phase == PH_RECV) ? 51 :
                                                (phase == PH_BOTH) ? 26 : 0);
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    while (idle_cycles < WATCHDOG_MAX) @(posedge clk_i);
    $display("Verification failed");
    $finish;
  end

  initial begin
    build_stimulus();
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    while (rx_bytes.size() != 0 || s_axis_tvalid || expected_samples.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
